FILE: rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// SPI EEPROM posted-write engine package
// Shared types, command and result codes, and SPI opcodes.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int CMD_W       = 3;
   localparam int KIND_W      = 3;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 48;
   localparam int ADDR_W      = 14;
   localparam int FRAME_BYTES = 7;
   localparam int COUNT_W     = 3;

   localparam int TYPES_PER_CHANNEL = 16;

   localparam logic [CMD_W-1:0] CMD_POST   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STATUS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DATA   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_POSTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SPI    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WORD   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BUSY   = 3'd5;

   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] SR_WIP   = 8'h01;
   localparam logic [7:0] SR_WEL   = 8'h02;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_POLL,
      PH_READ
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FETCH,
      ST_ADDR,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [8*FRAME_BYTES-1:0] bytes;
      logic [FRAME_BYTES-1:0]   fend;
      logic [COUNT_W-1:0]       count;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [7:0]  channel;
      logic [3:0]  entry_type;
      logic [31:0] data_word;
   } slot_type;

endpackage

FILE: rtl/spe_queue.sv
// ----------------------------------------------------------------------------
// Posted write queue
// Ring buffer of pending writes with one slot kept free; registered read.
// ----------------------------------------------------------------------------
module spe_queue
   import spe_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  slot_type         push_slot,
   input  logic             pop,
   output slot_type         pop_slot,
   output queue_status_type status
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] head_next, tail_next;
   slot_type      mem [DEPTH];
   slot_type      rd_ff;

   // Pointers wrap at DEPTH, which need not be a power of two.
   assign head_next = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   assign status.full  = (head_next == tail_ff);
   assign status.empty = (head_ff == tail_ff);
   assign pop_slot     = rd_ff;

   always_comb begin
      head_in = push ? head_next : head_ff;
      tail_in = pop ? tail_next : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // A post stores one past the head; a pop reads one past the tail.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[head_next] <= push_slot;
      end
      if (pop) begin
         rd_ff <= mem[tail_next];
      end
   end

   a_no_push_and_pop : assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("queue pushed and popped in the same cycle");

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue push while full");

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      pop |=> ($past(head_ff) != $past(tail_ff)))
      else $error("queue pop while empty");

endmodule

FILE: rtl/spe_shift.sv
// ----------------------------------------------------------------------------
// SPI frame shifter
// Holds one command frame and hands it out one byte per beat, lowest first.
// ----------------------------------------------------------------------------
module spe_shift
   import spe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  frame_type  load_frame,
   input  logic       advance,
   output logic [7:0] out_byte,
   output logic       out_fend,
   output logic       out_last,
   output logic       active
);

   logic [8*FRAME_BYTES-1:0] bytes_ff, bytes_in;
   logic [FRAME_BYTES-1:0]   fend_ff, fend_in;
   logic [COUNT_W-1:0]       count_ff, count_in;

   always_comb begin
      bytes_in = bytes_ff;
      fend_in  = fend_ff;
      count_in = count_ff;
      if (load) begin
         bytes_in = load_frame.bytes;
         fend_in  = load_frame.fend;
         count_in = load_frame.count;
      end else if (advance) begin
         bytes_in = bytes_ff >> 8;
         fend_in  = fend_ff >> 1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      fend_ff  <= fend_in;
   end

   assign out_byte = bytes_ff[7:0];
   assign out_fend = fend_ff[0];
   assign out_last = (count_ff == COUNT_W'(1));
   assign active   = (count_ff != '0);

endmodule

FILE: rtl/spi_eeprom_posted_write_engine.sv
// ----------------------------------------------------------------------------
// SPI EEPROM posted-write engine
// Queues posted writes and sequences WREN/RDSR polls, WRITE and READ frames.
// ----------------------------------------------------------------------------
// An item is captured in the idle state and decided once the output is free; a
// single result (posted, full, empty, busy, read word) is registered, ready again.
// A frame passes its load states, then one beat per byte through the frame shifter:
// status reply LOAD (7 or 3 bytes), read request ADDR, LOAD (7), service tick FETCH,
// ADDR, LOAD (3). An output stall holds a beat until it is taken.
// Synchronous reset empties the queue and returns to the idle phase.
module spi_eeprom_posted_write_engine
   import spe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel[7:0], entry_type[11:8], data_word[43:12], reply_byte[51:44], zeros
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // spi_byte[7:0], frame_end[8], read_word[40:9], zeros
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind[2:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic [11:0] TPC_LOW = 12'(TYPES_PER_CHANNEL);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CMD_W-1:0] cmd_ff;
   logic [7:0]       ch_ff, rb_ff;
   logic [3:0]       ty_ff;
   logic [31:0]      word_ff, active_word_ff, acc_ff, acc_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0]       cnt_ff, cnt_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_fend_ff, out_fend_in;
   logic [31:0]       out_word_ff, out_word_in;
   logic              out_last_ff, out_last_in;

   logic              out_free, status_ok, capture, fetch, addr_en;
   logic              push, pop, single, load, advance;
   logic [KIND_W-1:0] single_kind;
   logic [31:0]       single_word;
   logic [11:0]       addr_idx;
   frame_type         frame;
   slot_type          push_slot, pop_slot;
   queue_status_type  qstat;
   logic [7:0]        sh_byte;
   logic              sh_fend, sh_last, sh_active;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign status_ok  = ((rb_ff & (SR_WIP | SR_WEL)) == SR_WEL);
   assign req_tready = (state_ff == ST_IDLE);

   assign push_slot.channel    = ch_ff;
   assign push_slot.entry_type = ty_ff;
   assign push_slot.data_word  = word_ff;

   spe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_slot (push_slot),
      .pop       (pop),
      .pop_slot  (pop_slot),
      .status    (qstat)
   );

   spe_shift u_shift (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_frame (frame),
      .advance    (advance),
      .out_byte   (sh_byte),
      .out_fend   (sh_fend),
      .out_last   (sh_last),
      .active     (sh_active)
   );

   // Entry address: (channel * types + entry_type) * 4, kept to 14 bits.
   assign addr_idx = ({4'd0, ch_ff} * TPC_LOW) + {8'd0, ty_ff};

   always_comb begin
      if (cmd_ff == CMD_READ) begin
         frame.bytes = {32'd0, addr_ff[7:0], {2'b00, addr_ff[13:8]}, OP_READ};
         frame.fend  = 7'b1000000;
         frame.count = 3'd7;
      end else if ((cmd_ff == CMD_STATUS) && status_ok) begin
         frame.bytes = {active_word_ff[7:0], active_word_ff[15:8],
                        active_word_ff[23:16], active_word_ff[31:24],
                        addr_ff[7:0], {2'b00, addr_ff[13:8]}, OP_WRITE};
         frame.fend  = 7'b1000000;
         frame.count = 3'd7;
      end else begin
         frame.bytes = {40'd0, OP_RDSR, OP_WREN};
         frame.fend  = 7'b0000101;
         frame.count = 3'd3;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               if ((cmd_ff == CMD_READ) && (phase_ff == PH_IDLE)) begin
                  state_in = ST_ADDR;
               end else if ((cmd_ff == CMD_TICK) && (phase_ff == PH_IDLE) &&
                            !qstat.empty) begin
                  state_in = ST_FETCH;
               end else if ((cmd_ff == CMD_STATUS) && (phase_ff == PH_POLL)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FETCH: state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free && sh_last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      capture     = 1'b0;
      fetch       = 1'b0;
      addr_en     = 1'b0;
      push        = 1'b0;
      pop         = 1'b0;
      single      = 1'b0;
      load        = 1'b0;
      advance     = 1'b0;
      single_kind = KIND_BUSY;
      single_word = '0;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      unique case (state_ff)
         ST_IDLE: capture = req_tvalid;
         ST_DECIDE: begin
            if (out_free) begin
               unique case (cmd_ff)
                  CMD_POST: begin
                     single = 1'b1;
                     if (qstat.full) begin
                        single_kind = KIND_FULL;
                     end else begin
                        push        = 1'b1;
                        single_kind = KIND_POSTED;
                     end
                  end
                  CMD_READ: begin
                     if (phase_ff != PH_IDLE) begin
                        single = 1'b1;
                     end else begin
                        phase_in = PH_READ;
                        acc_in   = '0;
                        cnt_in   = '0;
                     end
                  end
                  CMD_TICK: begin
                     if (phase_ff != PH_IDLE) begin
                        single = 1'b1;
                     end else if (qstat.empty) begin
                        single      = 1'b1;
                        single_kind = KIND_EMPTY;
                     end else begin
                        pop      = 1'b1;
                        phase_in = PH_POLL;
                     end
                  end
                  CMD_STATUS: begin
                     if (phase_ff != PH_POLL) begin
                        single = 1'b1;
                     end else if (status_ok) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  CMD_DATA: begin
                     if (phase_ff != PH_READ) begin
                        single = 1'b1;
                     end else begin
                        acc_in = {acc_ff[23:0], rb_ff};
                        if (cnt_ff == 3'd3) begin
                           single      = 1'b1;
                           single_kind = KIND_WORD;
                           single_word = acc_in;
                           cnt_in      = '0;
                           phase_in    = PH_IDLE;
                        end else begin
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end
                  end
                  default: single = 1'b1;
               endcase
            end
         end
         ST_FETCH: fetch   = 1'b1;
         ST_ADDR:  addr_en = 1'b1;
         ST_LOAD:  load    = 1'b1;
         ST_EMIT:  advance = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_fend_in  = out_fend_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      if (single) begin
         out_valid_in = 1'b1;
         out_kind_in  = single_kind;
         out_byte_in  = '0;
         out_fend_in  = 1'b0;
         out_word_in  = single_word;
         out_last_in  = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_SPI;
         out_byte_in  = sh_byte;
         out_fend_in  = sh_fend;
         out_word_in  = '0;
         out_last_in  = sh_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         if (addr_en) addr_ff <= {addr_idx, 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_fend_ff <= out_fend_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
      if (capture) begin
         cmd_ff  <= req_tuser;
         ch_ff   <= req_tdata[7:0];
         ty_ff   <= req_tdata[11:8];
         word_ff <= req_tdata[43:12];
         rb_ff   <= req_tdata[51:44];
      end else if (fetch) begin
         ch_ff <= pop_slot.channel;
         ty_ff <= pop_slot.entry_type;
      end
      if (fetch) begin
         active_word_ff <= pop_slot.data_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_word_ff, out_fend_ff, out_byte_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_READ) |-> (cnt_ff == '0))
      else $error("read byte count nonzero outside read gather");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READ) |-> (cnt_ff < 3'd4))
      else $error("read byte count out of range");

   a_emit_has_frame : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> sh_active)
      else $error("frame emit with empty shifter");

endmodule
